// ===== src/pajr_pkg.sv =====
package pajr_pkg;

	localparam int PHASE_W = 32;
	localparam int CORDIC_W = 34;
	localparam int TRIG_W = 32;
	localparam int ATAN_N = 24;
	localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

	localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Divider formats: numerator is a Q46 sum, denominator a link length times a sine.
	localparam int NUM_W = 65;
	localparam int DEN_W = 54;
	localparam int QB = 42;
	localparam int FRAC = 16;
	localparam int PRE_SHIFT = QB - FRAC;
	localparam int MAG_W = 41;
	localparam int QUO_W = MAG_W + 1;
	localparam logic [QB-1:0] RATE_LIM = 42'h100_0000_0000;

	localparam int LEN_W = 21;
	localparam int OFS_W = 22;
	localparam int CFG_W = 22;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_FIRST_LINK = 2'd0;
	localparam logic [IDX_W-1:0] REG_SECOND_LINK = 2'd1;
	localparam logic [IDX_W-1:0] REG_BASE_HEIGHT = 2'd2;
	localparam logic [IDX_W-1:0] REG_TOOL_DROP = 2'd3;

	localparam logic [LEN_W-1:0] FIRST_LINK_RST = 21'd32768;
	localparam logic [LEN_W-1:0] SECOND_LINK_RST = 21'd32768;
	localparam logic [OFS_W-1:0] BASE_HEIGHT_RST = 22'd11403;
	localparam logic [OFS_W-1:0] TOOL_DROP_RST = 22'd37506;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ===== src/pajr_if.sv =====
interface pajr_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] shoulder_angle;
	logic signed [15:0] elbow_angle;
	logic signed [31:0] prism_extension;
	logic signed [31:0] cmd_vel_x;
	logic signed [31:0] cmd_vel_y;
	logic signed [31:0] cmd_vel_z;

	modport source(output valid, shoulder_angle, elbow_angle, prism_extension,
		cmd_vel_x, cmd_vel_y, cmd_vel_z, input ready);
	modport sink(input valid, shoulder_angle, elbow_angle, prism_extension,
		cmd_vel_x, cmd_vel_y, cmd_vel_z, output ready);
endinterface

interface pajr_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] shoulder_rate;
	logic signed [31:0] elbow_rate;
	logic signed [31:0] prism_rate;
	logic signed [31:0] tip_x;
	logic signed [31:0] tip_y;
	logic signed [31:0] tip_z;
	logic singular;

	modport source(output valid, shoulder_rate, elbow_rate, prism_rate, tip_x, tip_y,
		tip_z, singular, input ready);
	modport sink(input valid, shoulder_rate, elbow_rate, prism_rate, tip_x, tip_y,
		tip_z, singular, output ready);
endinterface

// ===== src/pajr_cordic.sv =====
module pajr_cordic import pajr_pkg::*; #(
	parameter int STAGES = 16
) (
	input logic clk,
	input logic en,
	input logic [PHASE_W-1:0] phase,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val
);

	logic signed [CORDIC_W-1:0] x_s [STAGES+1];
	logic signed [CORDIC_W-1:0] y_s [STAGES+1];
	logic signed [CORDIC_W-1:0] z_s [STAGES+1];
	logic flip_s [STAGES+1];
	logic flip;
	logic [PHASE_W-1:0] folded;

	// Second and third quadrants are folded by half a turn and negated at the end.
	assign flip = phase[PHASE_W-1] ^ phase[PHASE_W-2];
	assign folded = phase ^ {flip, {(PHASE_W-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= CORDIC_W'($signed(folded));
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({2'b00, ATAN_TURN[i]});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({2'b00, ATAN_TURN[i]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= TRIG_W'(flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES]);
			sin_val <= TRIG_W'(flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES]);
		end
	end

endmodule

// ===== src/pajr_div.sv =====
module pajr_div import pajr_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [NUM_W-1:0] num,
	input logic signed [DEN_W-1:0] den,
	output logic signed [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] r_s [QB+1];
	logic [DEN_W-1:0] d_s [QB+1];
	logic [QB-1:0] l_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic neg_s [QB+1];
	logic big_s [QB+1];
	logic [NUM_W-1:0] nmag;
	logic [DEN_W-1:0] dmag;
	logic big;
	logic [MAG_W-1:0] mag;

	assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dmag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

	// The dividend is |num| shifted up by the fraction bits; its top part seeds the remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= DEN_W'(nmag >> PRE_SHIFT);
			l_s[0] <= {nmag[PRE_SHIFT-1:0], {FRAC{1'b0}}};
			d_s[0] <= dmag;
			q_s[0] <= '0;
			neg_s[0] <= num[NUM_W-1] ^ den[DEN_W-1];
			big_s[0] <= 1'b0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic fits;
		assign trial = {r_s[k], l_s[k][QB-1]};
		assign fits = trial >= {1'b0, d_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= fits ? DEN_W'(trial - {1'b0, d_s[k]}) : DEN_W'(trial);
				l_s[k+1] <= {l_s[k][QB-2:0], 1'b0};
				d_s[k+1] <= d_s[k];
				q_s[k+1] <= {q_s[k][QB-2:0], fits};
				neg_s[k+1] <= neg_s[k];
				// A seed remainder at or above the divisor means the quotient overflows.
				big_s[k+1] <= big_s[k] | ((k == 0) && (r_s[k] >= d_s[k]));
			end
		end
	end

	assign big = big_s[QB] | (q_s[QB] > RATE_LIM);
	assign mag = big ? RATE_LIM[MAG_W-1:0] : q_s[QB][MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

// ===== src/pajr_pipe.sv =====
module pajr_pipe import pajr_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [W-1:0] in_data,
	output logic out_valid,
	output logic [W-1:0] out_data
);

	logic vld_s [DEPTH];
	logic [W-1:0] dat_s [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= (i == 0) ? in_valid : vld_s[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_s[i] <= (i == 0) ? in_data : dat_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_data = dat_s[DEPTH-1];

endmodule

// ===== src/planar_arm_joint_rate_resolver.sv =====
// Joint rate resolver for a two-link planar arm with a vertical prismatic axis. Each transfer
// carries two joint angles, an extension and a tip velocity, and yields one result with the
// inverse-Jacobian joint rates and the forward-kinematics tip position. The datapath is a
// single pipeline that takes one item every cycle unless stalled; each result passes the
// CORDIC stages with their input and output registers (TRIG_STAGES + 2), two multiply-and-sum
// stages, the 44-stage restoring dividers that form the rates, and the output register.
// A stall on the output holds the whole pipeline. A zero elbow sine or a zero link length
// yields zero shoulder and elbow rates with singular set. The user must write link lengths and
// offsets through the register port only while no item is in flight; nothing enforces it.
module planar_arm_joint_rate_resolver import pajr_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_index,
	input logic [CFG_W-1:0] wr_data,
	pajr_in_if.sink in_item,
	pajr_out_if.source out_item
);

	localparam logic [PHASE_W-1:0] QMASK = ~((PHASE_W'(1) << (PHASE_W - ANGLE_BITS)) -
		PHASE_W'(1));
	localparam int LC = TRIG_STAGES + 2;
	localparam int LD = QB + 2;
	localparam int SA_W = 4 * 32 + 1;
	localparam int SB_W = 4 * 32 + 1;

	logic [LEN_W-1:0] l1_q, l2_q;
	logic [OFS_W-1:0] base_q, tool_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= FIRST_LINK_RST;
			l2_q <= SECOND_LINK_RST;
			base_q <= BASE_HEIGHT_RST;
			tool_q <= TOOL_DROP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FIRST_LINK: l1_q <= wr_data[LEN_W-1:0];
				REG_SECOND_LINK: l2_q <= wr_data[LEN_W-1:0];
				REG_BASE_HEIGHT: base_q <= wr_data;
				REG_TOOL_DROP: tool_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic adv, take;
	logic out_valid_q;

	assign adv = !out_valid_q || out_item.ready;
	assign take = in_item.valid && adv;
	assign in_item.ready = adv;

	logic [PHASE_W-1:0] ps, pe, pse;
	logic pe_sing;

	assign ps = {in_item.shoulder_angle, 16'b0} & QMASK;
	assign pe = {in_item.elbow_angle, 16'b0} & QMASK;
	assign pse = (ps + pe) & QMASK;
	assign pe_sing = (pe == '0) || (pe == 32'h8000_0000);

	logic signed [TRIG_W-1:0] c1, s1, ce, se, c12, s12;

	pajr_cordic #(.STAGES(TRIG_STAGES)) u_trig_s (
		.clk(clk), .en(adv), .phase(ps), .cos_val(c1), .sin_val(s1));
	pajr_cordic #(.STAGES(TRIG_STAGES)) u_trig_e (
		.clk(clk), .en(adv), .phase(pe), .cos_val(ce), .sin_val(se));
	pajr_cordic #(.STAGES(TRIG_STAGES)) u_trig_se (
		.clk(clk), .en(adv), .phase(pse), .cos_val(c12), .sin_val(s12));

	logic va;
	logic [SA_W-1:0] sa;
	logic signed [31:0] vx_a, vy_a, vz_a, ext_a;
	logic sing_a;

	pajr_pipe #(.W(SA_W), .DEPTH(LC)) u_side_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(take),
		.in_data({in_item.cmd_vel_x, in_item.cmd_vel_y, in_item.cmd_vel_z,
			in_item.prism_extension, pe_sing}),
		.out_valid(va), .out_data(sa));

	assign {vx_a, vy_a, vz_a, ext_a, sing_a} = sa;

	// Stage 1: products.
	logic v_s1, sing_s1;
	logic signed [31:0] vz_s1, ext_s1;
	logic signed [DEN_W-1:0] l1c1_s1, l2c12_s1, l1s1_s1, l2s12_s1, d1_s1, d2_s1;
	logic signed [63:0] c12vx_s1, s12vy_s1, c1vx_s1, s1vy_s1;
	logic signed [LEN_W:0] l1_sx, l2_sx;

	assign l1_sx = $signed({1'b0, l1_q});
	assign l2_sx = $signed({1'b0, l2_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l1c1_s1 <= DEN_W'(l1_sx * c1);
			l2c12_s1 <= DEN_W'(l2_sx * c12);
			l1s1_s1 <= DEN_W'(l1_sx * s1);
			l2s12_s1 <= DEN_W'(l2_sx * s12);
			d1_s1 <= DEN_W'(l1_sx * se);
			d2_s1 <= DEN_W'(l2_sx * se);
			c12vx_s1 <= c12 * vx_a;
			s12vy_s1 <= s12 * vy_a;
			c1vx_s1 <= c1 * vx_a;
			s1vy_s1 <= s1 * vy_a;
			vz_s1 <= vz_a;
			ext_s1 <= ext_a;
			sing_s1 <= sing_a || (l1_q == '0) || (l2_q == '0) || (se == '0);
		end
	end

	// Stage 2: sums and rounding.
	logic v_s2, sing_s2;
	logic signed [31:0] vz_s2, tx_s2, ty_s2, tz_s2;
	logic signed [NUM_W-1:0] n1_s2, n2_s2;
	logic signed [DEN_W-1:0] d1_s2, d2_s2;
	logic signed [DEN_W:0] sum_x, sum_y;
	logic signed [47:0] sum_z;

	assign sum_x = (DEN_W+1)'(l1c1_s1) + (DEN_W+1)'(l2c12_s1) + (DEN_W+1)'(1 << 29);
	assign sum_y = (DEN_W+1)'(l1s1_s1) + (DEN_W+1)'(l2s12_s1) + (DEN_W+1)'(1 << 29);
	assign sum_z = 48'($signed(base_q)) + 48'(ext_s1) - 48'($signed(tool_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s2 <= 32'($signed(sum_x[DEN_W:30]));
			ty_s2 <= 32'($signed(sum_y[DEN_W:30]));
			tz_s2 <= sat32(sum_z);
			n1_s2 <= NUM_W'(c12vx_s1) + NUM_W'(s12vy_s1);
			n2_s2 <= NUM_W'(c1vx_s1) + NUM_W'(s1vy_s1);
			d1_s2 <= d1_s1;
			d2_s2 <= d2_s1;
			vz_s2 <= vz_s1;
			sing_s2 <= sing_s1;
		end
	end

	logic signed [QUO_W-1:0] wsh, wq;

	pajr_div u_div_sh (.clk(clk), .en(adv), .num(n1_s2), .den(d1_s2), .quo(wsh));
	pajr_div u_div_q (.clk(clk), .en(adv), .num(n2_s2), .den(d2_s2), .quo(wq));

	logic vb;
	logic [SB_W-1:0] sb;
	logic signed [31:0] vz_b, tx_b, ty_b, tz_b;
	logic sing_b;

	pajr_pipe #(.W(SB_W), .DEPTH(LD)) u_side_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s2),
		.in_data({vz_s2, tx_s2, ty_s2, tz_s2, sing_s2}),
		.out_valid(vb), .out_data(sb));

	assign {vz_b, tx_b, ty_b, tz_b, sing_b} = sb;

	logic signed [47:0] el_sum;
	assign el_sum = -(48'(wq) + 48'(wsh));

	logic signed [31:0] sh_q, el_q, pr_q, tx_q, ty_q, tz_q;
	logic sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_q <= sing_b ? '0 : sat32(48'(wsh));
			el_q <= sing_b ? '0 : sat32(el_sum);
			pr_q <= vz_b;
			tx_q <= tx_b;
			ty_q <= ty_b;
			tz_q <= tz_b;
			sing_q <= sing_b;
		end
	end

	assign out_item.valid = out_valid_q;
	assign out_item.shoulder_rate = sh_q;
	assign out_item.elbow_rate = el_q;
	assign out_item.prism_rate = pr_q;
	assign out_item.tip_x = tx_q;
	assign out_item.tip_y = ty_q;
	assign out_item.tip_z = tz_q;
	assign out_item.singular = sing_q;

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sing_q |-> sh_q == '0 && el_q == '0)
		else $error("singular result carries nonzero rates");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s2) && $stable(v_s1))
		else $error("pipeline valid moved during a stall");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vb |=> out_valid_q)
		else $error("finished item did not reach the output register");

endmodule
